FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top level RTL file of the unescaper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define JSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/jsu_pkg.sv
// Types, constants and helper functions of the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [6:0] {
    MODE_IDLE  = 7'b0000001,
    MODE_STR   = 7'b0000010,
    MODE_ESC   = 7'b0000100,
    MODE_HEXA  = 7'b0001000,
    MODE_EXPBS = 7'b0010000,
    MODE_EXPU  = 7'b0100000,
    MODE_HEXB  = 7'b1000000
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  localparam int unsigned MaxResults = 4;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChFf        = 8'h0C;
  localparam logic [7:0] ChBs        = 8'h08;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;

  localparam logic [5:0] HighSurrTag = 6'b110110;
  localparam logic [5:0] LowSurrTag  = 6'b110111;
  localparam logic [4:0] SurrTag     = 5'b11011;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] acc;
    logic [1:0]  cnt;
    logic [15:0] held;
  } ctx_t;

  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    kind_t [MaxResults-1:0]     kinds;
    logic [2:0]                 count;
  } res_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/jsu_ifs.sv
// Word channels of the unescaper: raw text in, decoded results out.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       last;

  modport source (output valid, output out_byte, output out_kind, output last, input ready);
  modport sink   (input valid, input out_byte, input out_kind, input last, output ready);
endinterface

FILE: rtl/core/json_string_unescape.sv
// Top level of the JSON string unescaper.
//
// The rx channel takes one word of JSON text per handshake: in_byte, or
// text_end to mark the end of the text. The tx channel gives decoded
// results: a data byte (out_kind 0), string complete (1) or parse error (2),
// with last set on the final result that an input word causes.
// A word taken on rx is held in the input register and decoded there; once
// the result buffer is free, its results, up to four, are loaded into it.
// The first result is then valid on tx.
// A word that gives one result or none does not hold up the next, so one
// word per cycle is sustained while tx does not stall; after a word that
// gives more results, the next word waits in the input register while the
// buffer drains, one result per cycle while tx is ready, and rx holds ready low until the last result is being taken.
// When tx stalls, the buffer and then the input register hold, and rx
// drops ready; nothing is lost. Words that give no result never reach tx.
// Reset (rst, synchronous) empties both registers and returns the parser
// to the state outside any string.
module json_string_unescape
  import jsu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  jsu_in_if.sink    rx,
  jsu_out_if.source tx
);

  `include "assert_macros.svh"

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_end;

  logic [MaxResults-1:0][7:0] buf_bytes;
  kind_t [MaxResults-1:0]     buf_kinds;
  logic [2:0]                 rem;
  logic [1:0]                 pos;

  res_t res;
  logic buf_free;
  logic s1_move;
  logic tx_marker;

  assign buf_free = (rem == 3'd0) || (rem == 3'd1 && tx.ready);
  assign s1_move  = s1_valid && buf_free;
  assign rx.ready = !s1_valid || buf_free;

  jsu_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_move),
    .in_byte  (s1_byte),
    .text_end (s1_end),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.in_byte;
      s1_end  <= rx.text_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
      pos <= 2'd0;
    end else if (s1_move) begin
      rem <= res.count;
      pos <= 2'd0;
    end else if (tx.valid && tx.ready) begin
      rem <= rem - 3'd1;
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      buf_bytes <= res.bytes;
      buf_kinds <= res.kinds;
    end
  end

  assign tx.valid    = (rem != 3'd0);
  assign tx.out_byte = buf_bytes[pos];
  assign tx.out_kind = buf_kinds[pos];
  assign tx.last     = (rem == 3'd1);

  assign tx_marker = tx.valid && (tx.out_kind != KIND_DATA);

  `JSU_ASSERT(a_move_when_drained, s1_move |-> buf_free, "word decoded over pending results")
  `JSU_ASSERT(a_marker_alone, tx_marker |-> (tx.last && tx.out_byte == 8'd0), "bad marker word")
  `JSU_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> (!tx.valid && !s1_valid), "not empty after reset")

endmodule

FILE: rtl/core/jsu_decode.sv
// Parser state and the per-word decode of escapes into result bytes.
module jsu_decode
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  logic       text_end,
  output res_t       res
);

  ctx_t ctx;
  ctx_t ctx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= '{mode: MODE_IDLE, acc: 16'd0, cnt: 2'd0, held: 16'd0};
    end else if (step) begin
      ctx <= ctx_next;
    end
  end

  always_comb begin
    logic [15:0] acc_new;
    logic [20:0] cp;
    acc_new = {ctx.acc[11:0], hex_value(in_byte)};
    cp = 21'h10000 + {1'b0, ctx.held[9:0], acc_new[9:0]};
    ctx_next = ctx;
    res.bytes = '0;
    res.kinds = {MaxResults{KIND_DATA}};
    res.count = 3'd0;
    if (text_end) begin
      if (ctx.mode != MODE_IDLE) begin
        ctx_next = '{mode: MODE_IDLE, acc: 16'd0, cnt: 2'd0, held: 16'd0};
        res.kinds[0] = KIND_ERR;
        res.count = 3'd1;
      end
    end else begin
      case (ctx.mode)
        MODE_IDLE: begin
          if (in_byte == ChQuote) begin
            ctx_next.mode = MODE_STR;
          end else if (in_byte != ChSpace && in_byte != ChTab &&
                       in_byte != ChLf && in_byte != ChCr) begin
            ctx_next = '{mode: MODE_IDLE, acc: 16'd0, cnt: 2'd0, held: 16'd0};
            res.kinds[0] = KIND_ERR;
            res.count = 3'd1;
          end
        end
        MODE_STR: begin
          if (in_byte == ChQuote) begin
            ctx_next.mode = MODE_IDLE;
            res.kinds[0] = KIND_DONE;
            res.count = 3'd1;
          end else if (in_byte == ChBackslash) begin
            ctx_next.mode = MODE_ESC;
          end else begin
            res.bytes[0] = in_byte;
            res.count = 3'd1;
          end
        end
        MODE_ESC: begin
          ctx_next.mode = MODE_STR;
          res.count = 3'd1;
          case (in_byte)
            ChLowerB: res.bytes[0] = ChBs;
            ChLowerF: res.bytes[0] = ChFf;
            ChLowerN: res.bytes[0] = ChLf;
            ChLowerR: res.bytes[0] = ChCr;
            ChLowerT: res.bytes[0] = ChTab;
            ChLowerU: begin
              ctx_next.mode = MODE_HEXA;
              ctx_next.acc = 16'd0;
              ctx_next.cnt = 2'd0;
              res.count = 3'd0;
            end
            default: res.bytes[0] = in_byte;
          endcase
        end
        MODE_HEXA: begin
          if (ctx.cnt == 2'd3) begin
            ctx_next.cnt = 2'd0;
            ctx_next.acc = 16'd0;
            if (acc_new[15:11] == SurrTag) begin
              ctx_next.held = acc_new;
              ctx_next.mode = MODE_EXPBS;
            end else begin
              ctx_next.mode = MODE_STR;
              if (acc_new[15:7] == 9'd0) begin
                res.bytes[0] = {1'b0, acc_new[6:0]};
                res.count = 3'd1;
              end else if (acc_new[15:11] == 5'd0) begin
                res.bytes[0] = {3'b110, acc_new[10:6]};
                res.bytes[1] = {2'b10, acc_new[5:0]};
                res.count = 3'd2;
              end else begin
                res.bytes[0] = {4'b1110, acc_new[15:12]};
                res.bytes[1] = {2'b10, acc_new[11:6]};
                res.bytes[2] = {2'b10, acc_new[5:0]};
                res.count = 3'd3;
              end
            end
          end else begin
            ctx_next.acc = acc_new;
            ctx_next.cnt = ctx.cnt + 2'd1;
          end
        end
        MODE_EXPBS: begin
          if (in_byte == ChBackslash) begin
            ctx_next.mode = MODE_EXPU;
          end else begin
            ctx_next = '{mode: MODE_IDLE, acc: 16'd0, cnt: 2'd0, held: 16'd0};
            res.kinds[0] = KIND_ERR;
            res.count = 3'd1;
          end
        end
        MODE_EXPU: begin
          if (in_byte == ChLowerU) begin
            ctx_next.mode = MODE_HEXB;
            ctx_next.acc = 16'd0;
            ctx_next.cnt = 2'd0;
          end else begin
            ctx_next = '{mode: MODE_IDLE, acc: 16'd0, cnt: 2'd0, held: 16'd0};
            res.kinds[0] = KIND_ERR;
            res.count = 3'd1;
          end
        end
        MODE_HEXB: begin
          if (ctx.cnt == 2'd3) begin
            ctx_next.cnt = 2'd0;
            ctx_next.acc = 16'd0;
            ctx_next.held = 16'd0;
            ctx_next.mode = MODE_STR;
            if (ctx.held[15:10] == HighSurrTag && acc_new[15:10] == LowSurrTag) begin
              res.bytes[0] = {5'b11110, cp[20:18]};
              res.bytes[1] = {2'b10, cp[17:12]};
              res.bytes[2] = {2'b10, cp[11:6]};
              res.bytes[3] = {2'b10, cp[5:0]};
              res.count = 3'd4;
            end
          end else begin
            ctx_next.acc = acc_new;
            ctx_next.cnt = ctx.cnt + 2'd1;
          end
        end
        default: begin
          ctx_next.mode = MODE_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: dv/testbench.sv
// Self-checking testbench of the JSON string unescaper, with random handshakes on both channels.
`timescale 1ns / 100ps

module testbench;
  import jsu_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned RandomWords = 300;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } decoded_t;

  class unescape_scoreboard;
    decoded_t    decoded_q[$];
    mode_t       mode;
    logic [15:0] acc;
    logic [1:0]  digits;
    logic [15:0] high_unit;
    int unsigned errors;

    function new();
      mode      = MODE_IDLE;
      acc       = '0;
      digits    = '0;
      high_unit = '0;
      errors    = 0;
    endfunction

    function int unsigned pending();
      return decoded_q.size();
    endfunction

    function void emit(logic [7:0] d, kind_t k);
      decoded_t r;
      r.data = d;
      r.kind = k;
      r.last = 1'b0;
      decoded_q = {decoded_q, r};
    endfunction

    function void raise_error();
      mode      = MODE_IDLE;
      acc       = '0;
      digits    = '0;
      high_unit = '0;
      emit(8'h00, KIND_ERR);
    endfunction

    function bit take_digit(logic [7:0] c);
      logic [3:0] v;
      bit         full;
      v = 4'd0;
      if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
          (c >= 8'h61 && c <= 8'h66)) begin
        v = c[6] ? c[3:0] + 4'd9 : c[3:0];
      end
      acc  = {acc[11:0], v};
      full = (digits == 2'd3);
      digits = full ? 2'd0 : digits + 2'd1;
      return full;
    endfunction

    function void note_word(logic [7:0] b, logic e);
      int unsigned n0;
      logic [15:0] u;
      logic [20:0] cp;
      n0 = decoded_q.size();
      if (e) begin
        if (mode != MODE_IDLE) raise_error();
      end else begin
        case (mode)
          MODE_IDLE: begin
            if (b == ChQuote) mode = MODE_STR;
            else if (!(b inside {ChSpace, ChTab, ChLf, ChCr})) raise_error();
          end
          MODE_STR: begin
            if (b == ChQuote) begin
              emit(8'h00, KIND_DONE);
              mode = MODE_IDLE;
            end else if (b == ChBackslash) begin
              mode = MODE_ESC;
            end else begin
              emit(b, KIND_DATA);
            end
          end
          MODE_ESC: begin
            mode = MODE_STR;
            case (b)
              ChLowerB: emit(ChBs, KIND_DATA);
              ChLowerF: emit(ChFf, KIND_DATA);
              ChLowerN: emit(ChLf, KIND_DATA);
              ChLowerR: emit(ChCr, KIND_DATA);
              ChLowerT: emit(ChTab, KIND_DATA);
              ChLowerU: begin
                mode   = MODE_HEXA;
                acc    = '0;
                digits = '0;
              end
              default: emit(b, KIND_DATA);
            endcase
          end
          MODE_HEXA: begin
            if (take_digit(b)) begin
              u = acc;
              if (u < 16'hD800 || u > 16'hDFFF) begin
                if (u < 16'h0080) begin
                  emit(u[7:0], KIND_DATA);
                end else if (u < 16'h0800) begin
                  emit({3'b110, u[10:6]}, KIND_DATA);
                  emit({2'b10, u[5:0]}, KIND_DATA);
                end else begin
                  emit({4'b1110, u[15:12]}, KIND_DATA);
                  emit({2'b10, u[11:6]}, KIND_DATA);
                  emit({2'b10, u[5:0]}, KIND_DATA);
                end
                mode = MODE_STR;
              end else begin
                high_unit = u;
                mode      = MODE_EXPBS;
              end
              acc = '0;
            end
          end
          MODE_EXPBS: begin
            if (b == ChBackslash) mode = MODE_EXPU;
            else raise_error();
          end
          MODE_EXPU: begin
            if (b == ChLowerU) begin
              mode   = MODE_HEXB;
              acc    = '0;
              digits = '0;
            end else begin
              raise_error();
            end
          end
          MODE_HEXB: begin
            if (take_digit(b)) begin
              if (high_unit >= 16'hD800 && high_unit <= 16'hDBFF &&
                  acc >= 16'hDC00 && acc <= 16'hDFFF) begin
                cp = 21'h10000 + {1'b0, high_unit[9:0], acc[9:0]};
                emit({5'b11110, cp[20:18]}, KIND_DATA);
                emit({2'b10, cp[17:12]}, KIND_DATA);
                emit({2'b10, cp[11:6]}, KIND_DATA);
                emit({2'b10, cp[5:0]}, KIND_DATA);
              end
              acc       = '0;
              high_unit = '0;
              mode      = MODE_STR;
            end
          end
          default: mode = MODE_IDLE;
        endcase
      end
      if (decoded_q.size() > n0) decoded_q[decoded_q.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [7:0] b, logic [1:0] k, logic l);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, got out_byte %02h out_kind %0d last %0b",
                 $time, b, k, l);
        return;
      end
      want = decoded_q.pop_front();
      if (b !== want.data) begin
        errors++;
        $display("%0t: out_byte expected %02h, got %02h", $time, want.data, b);
      end
      if (k !== want.kind) begin
        errors++;
        $display("%0t: out_kind expected %0d, got %0d", $time, want.kind, k);
      end
      if (l !== want.last) begin
        errors++;
        $display("%0t: last expected %0b, got %0b", $time, want.last, l);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   rx_calm;
  bit   tx_calm;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;
  unescape_scoreboard unescaper;

  jsu_in_if  rx_if ();
  jsu_out_if tx_if ();

  json_string_unescape i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_word(input logic [7:0] b, input logic e);
    int unsigned gap;
    gap = rx_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid    <= 1'b1;
    rx_if.in_byte  <= b;
    rx_if.text_end <= e;
    do @(posedge clk); while (!rx_if.ready);
    unescaper.note_word(b, e);
    words_sent++;
  endtask

  task automatic wait_for_results();
    rx_if.valid <= 1'b0;
    do @(posedge clk); while (unescaper.pending() != 0);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v == 4'd0 && $urandom_range(0, 3) == 0) return {1'b1, 7'($urandom)};
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  task automatic put_unit(input logic [15:0] u);
    send_word(ChBackslash, 1'b0);
    send_word(ChLowerU, 1'b0);
    for (int i = 3; i >= 0; i--) send_word(hex_char(u[i*4 +: 4]), 1'b0);
  endtask

  task automatic put_token(output bit broken);
    logic [7:0] c;
    broken = 1'b0;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6: begin
        do c = 8'($urandom); while (c == ChQuote || c == ChBackslash);
        send_word(c, 1'b0);
      end
      7, 8: begin
        case ($urandom_range(0, 7))
          0: c = ChLowerB;
          1: c = ChLowerF;
          2: c = ChLowerN;
          3: c = ChLowerR;
          4: c = ChLowerT;
          5: c = ChQuote;
          6: c = ChBackslash;
          default: c = 8'h2F;
        endcase
        send_word(ChBackslash, 1'b0);
        send_word(c, 1'b0);
      end
      9: begin
        do c = 8'($urandom); while (c == ChLowerU);
        send_word(ChBackslash, 1'b0);
        send_word(c, 1'b0);
      end
      10, 11: put_unit(16'($urandom_range(0, 'h7F)));
      12: put_unit(16'($urandom_range('h80, 'h7FF)));
      13, 14: begin
        if ($urandom_range(0, 1)) put_unit(16'($urandom_range('h800, 'hD7FF)));
        else put_unit(16'($urandom_range('hE000, 'hFFFF)));
      end
      15, 16: begin
        put_unit(16'($urandom_range('hD800, 'hDBFF)));
        put_unit(16'($urandom_range('hDC00, 'hDFFF)));
      end
      17: begin
        if ($urandom_range(0, 1)) begin
          put_unit(16'($urandom_range('hDC00, 'hDFFF)));
          put_unit(16'($urandom));
        end else begin
          put_unit(16'($urandom_range('hD800, 'hDBFF)));
          if ($urandom_range(0, 1)) put_unit(16'($urandom_range(0, 'hDBFF)));
          else put_unit(16'($urandom_range('hE000, 'hFFFF)));
        end
      end
      18: begin
        put_unit(16'($urandom_range('hD800, 'hDFFF)));
        if ($urandom_range(0, 1)) begin
          do c = 8'($urandom); while (c == ChBackslash);
        end else begin
          send_word(ChBackslash, 1'b0);
          do c = 8'($urandom); while (c == ChLowerU);
        end
        send_word(c, 1'b0);
        broken = 1'b1;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: put_unit(16'h0000);
          1: put_unit(16'h007F);
          2: put_unit(16'h0080);
          3: put_unit(16'h07FF);
          4: put_unit(16'h0800);
          default: put_unit(16'hFFFF);
        endcase
      end
    endcase
  endtask

  task automatic put_string();
    int unsigned tokens;
    int unsigned r;
    bit          broken;
    rx_calm = ($urandom_range(0, 3) == 0);
    tx_calm = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 15);
    if (r == 0) send_word(8'($urandom), 1'b0);
    else if (r == 1) send_word(8'($urandom), 1'b1);
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: send_word(ChSpace, 1'b0);
        1: send_word(ChTab, 1'b0);
        2: send_word(ChLf, 1'b0);
        default: send_word(ChCr, 1'b0);
      endcase
    end
    send_word(ChQuote, 1'b0);
    tokens = $urandom_range(0, 8);
    broken = 1'b0;
    while (tokens != 0 && !broken) begin
      put_token(broken);
      tokens--;
    end
    if (!broken) begin
      r = $urandom_range(0, 11);
      if (r < 10) send_word(ChQuote, 1'b0);
      else if (r == 10) send_word(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    int unsigned strings_done;
    unescaper = new();
    rx_calm = 1'b1;
    tx_calm = 1'b0;
    rst            <= 1'b1;
    rx_if.valid    <= 1'b0;
    rx_if.in_byte  <= 8'h00;
    rx_if.text_end <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Whitespace, a stray byte and the end of text are all seen outside a string.
    send_word(ChSpace, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(ChQuote, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(ChBackslash, 1'b0);
    send_word(ChLowerN, 1'b0);
    send_word(ChBackslash, 1'b0);
    send_word(8'h78, 1'b0);
    put_unit(16'hD83D);
    put_unit(16'hDE00);
    send_word(ChQuote, 1'b0);
    // A surrogate unit followed by a plain byte, then the text ends inside a string.
    send_word(ChQuote, 1'b0);
    put_unit(16'hD800);
    send_word(8'h78, 1'b0);
    send_word(ChQuote, 1'b0);
    send_word(8'h55, 1'b1);
    wait_for_results();

    strings_done = 0;
    while (words_sent < RandomWords + 33) begin
      put_string();
      strings_done++;
      if (strings_done % 12 == 0) wait_for_results();
    end
    wait_for_results();
    repeat (8) @(posedge clk);
    if (unescaper.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    tx_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = tx_calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        tx_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      tx_if.ready <= 1'b1;
      do @(posedge clk); while (!tx_if.valid);
      unescaper.check_result(tx_if.out_byte, tx_if.out_kind, tx_if.last);
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
